// ===== design/acl_pkg.sv =====
// Shared types, constants and a helper function for the IPv4 access list.
package acl_pkg;

  localparam int unsigned MAX_RULES_DEF = 1024;
  localparam int unsigned ADDR_W        = 32;
  localparam int unsigned PLEN_W        = 6;
  localparam int unsigned HIT_IDX_W     = 10;

  localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(32);

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_QUERY = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef struct packed {
    func_e              func;
    logic               deny;
    logic [ADDR_W-1:0]  address;
    logic [PLEN_W-1:0]  prefix;
  } acl_op_t;

  typedef struct packed {
    logic               deny;
    logic [PLEN_W-1:0]  prefix;
    logic [ADDR_W-1:0]  base;
  } acl_rule_t;

  localparam int unsigned RULE_W = $bits(acl_rule_t);

  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
    logic [ADDR_W-1:0] mask;
    if (plen == '0) begin
      mask = '0;
    end else begin
      mask = {ADDR_W{1'b1}} << (PLEN_MAX - plen);
    end
    return mask;
  endfunction

endpackage

// ===== design/acl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module acl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/acl_front.sv =====
// Front end: accepts input beats, drops unused operations and saturates the prefix.
module acl_front import acl_pkg::*; (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        func_i,
  input  logic              rule_deny_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [PLEN_W-1:0] prefix_len_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output acl_op_t           push_data_o
);

  logic known_func;

  assign known_func = (func_i == FUNC_LOAD) || (func_i == FUNC_QUERY) ||
                      (func_i == FUNC_CLEAR);

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i && known_func;

  always_comb begin
    push_data_o.func    = func_e'(func_i);
    push_data_o.deny    = rule_deny_i;
    push_data_o.address = address_i;
    push_data_o.prefix  = (prefix_len_i > PLEN_MAX) ? PLEN_MAX : prefix_len_i;
  end

endmodule

// ===== design/acl_fifo.sv =====
// Two-entry queue of decoded operations between the front end and the back end.
module acl_fifo import acl_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  acl_op_t in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output acl_op_t out_data_o
);

  acl_op_t    slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = slot_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_data_i;
    end
  end

endmodule

// ===== design/acl_back.sv =====
// Back end: stores rules, scans them one per cycle on a query and holds the result beat.
module acl_back import acl_pkg::*; #(
  parameter int unsigned MAX_RULES = MAX_RULES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 op_valid_i,
  output logic                 op_ready_o,
  input  acl_op_t              op_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic                 verdict_o,
  output logic                 hit_o,
  output logic [HIT_IDX_W-1:0] hit_index_o,
  output logic                 load_dropped_o
);

  localparam int unsigned IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_RULES + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     total_q, total_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic                 res_valid_q, res_valid_d;
  logic                 verdict_q, verdict_d;
  logic                 hit_q, hit_d;
  logic [HIT_IDX_W-1:0] hit_index_q, hit_index_d;
  logic                 dropped_q, dropped_d;

  logic                 slot_free;
  logic                 pop;
  logic                 full;
  logic                 we;
  logic                 re;
  logic [IDX_W-1:0]     raddr;
  acl_rule_t            wrule;
  acl_rule_t            rrule;
  logic [RULE_W-1:0]    rdata;
  logic                 match;
  logic [CNT_W-1:0]     next_pos;
  logic [HIT_IDX_W+IDX_W-1:0] idx_wide;

  assign slot_free  = !res_valid_q || res_ready_i;
  assign op_ready_o = (state_q == ST_IDLE) && slot_free;
  assign pop        = op_valid_i && op_ready_o;
  assign full       = (total_q == CNT_W'(MAX_RULES));

  assign wrule.deny   = op_i.deny;
  assign wrule.prefix = op_i.prefix;
  assign wrule.base   = op_i.address;

  assign rrule    = acl_rule_t'(rdata);
  assign match    = ((addr_q ^ rrule.base) & prefix_mask(rrule.prefix)) == '0;
  assign next_pos = CNT_W'(idx_q) + CNT_W'(1);
  assign idx_wide = {{HIT_IDX_W{1'b0}}, idx_q};

  acl_ram #(
    .WIDTH (RULE_W),
    .DEPTH (MAX_RULES)
  ) u_rule_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (total_q[IDX_W-1:0]),
    .wdata_i (wrule),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    idx_d       = idx_q;
    addr_d      = addr_q;
    res_valid_d = (res_valid_q && res_ready_i) ? 1'b0 : res_valid_q;
    verdict_d   = verdict_q;
    hit_d       = hit_q;
    hit_index_d = hit_index_q;
    dropped_d   = dropped_q;
    we          = 1'b0;
    re          = 1'b0;
    raddr       = '0;

    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          case (op_i.func)
            FUNC_LOAD: begin
              res_valid_d = 1'b1;
              verdict_d   = 1'b0;
              hit_d       = 1'b0;
              hit_index_d = '0;
              dropped_d   = full;
              if (!full) begin
                we      = 1'b1;
                total_d = total_q + CNT_W'(1);
              end
            end
            FUNC_QUERY: begin
              addr_d = op_i.address;
              if (total_q == '0) begin
                res_valid_d = 1'b1;
                verdict_d   = 1'b0;
                hit_d       = 1'b0;
                hit_index_d = '0;
                dropped_d   = 1'b0;
              end else begin
                re      = 1'b1;
                raddr   = '0;
                idx_d   = '0;
                state_d = ST_SCAN;
              end
            end
            FUNC_CLEAR: begin
              total_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (match) begin
          res_valid_d = 1'b1;
          verdict_d   = rrule.deny;
          hit_d       = 1'b1;
          hit_index_d = idx_wide[HIT_IDX_W-1:0];
          dropped_d   = 1'b0;
          state_d     = ST_IDLE;
        end else if (next_pos == total_q) begin
          res_valid_d = 1'b1;
          verdict_d   = 1'b0;
          hit_d       = 1'b0;
          hit_index_d = '0;
          dropped_d   = 1'b0;
          state_d     = ST_IDLE;
        end else begin
          re    = 1'b1;
          raddr = idx_q + IDX_W'(1);
          idx_d = idx_q + IDX_W'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    addr_q      <= addr_d;
    verdict_q   <= verdict_d;
    hit_q       <= hit_d;
    hit_index_q <= hit_index_d;
    dropped_q   <= dropped_d;
  end

  assign res_valid_o    = res_valid_q;
  assign verdict_o      = verdict_q;
  assign hit_o          = hit_q;
  assign hit_index_o    = hit_index_q;
  assign load_dropped_o = dropped_q;

endmodule

// ===== design/ipv4_acl_first_match.sv =====
// A load's result beat is registered once the back end takes the load from the queue. A query
// reads stored rules from position zero in order and registers its result at the first
// matching rule, or after the last rule when none matches. A clear takes effect when the back
// end takes it from the queue. Loads, clears and ignored beats go one per cycle while the
// result is not stalled; a query holds the back end while the memory reads one rule a cycle.
// Reset empties the rule list and the queue; rule memory contents are not cleared.
module ipv4_acl_first_match import acl_pkg::*; #(
  parameter int unsigned MAX_RULES = MAX_RULES_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           func_i,
  input  logic                 rule_deny_i,
  input  logic [ADDR_W-1:0]    address_i,
  input  logic [PLEN_W-1:0]    prefix_len_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 verdict_o,
  output logic                 hit_o,
  output logic [HIT_IDX_W-1:0] hit_index_o,
  output logic                 load_dropped_o
);

  logic    push_valid, push_ready;
  acl_op_t push_data;
  logic    op_valid, op_ready;
  acl_op_t op_data;

  acl_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .rule_deny_i  (rule_deny_i),
    .address_i    (address_i),
    .prefix_len_i (prefix_len_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  acl_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push_valid),
    .in_ready_o  (push_ready),
    .in_data_i   (push_data),
    .out_valid_o (op_valid),
    .out_ready_i (op_ready),
    .out_data_o  (op_data)
  );

  acl_back #(
    .MAX_RULES (MAX_RULES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (op_valid),
    .op_ready_o     (op_ready),
    .op_i           (op_data),
    .res_valid_o    (out_valid_o),
    .res_ready_i    (out_ready_i),
    .verdict_o      (verdict_o),
    .hit_o          (hit_o),
    .hit_index_o    (hit_index_o),
    .load_dropped_o (load_dropped_o)
  );

endmodule

// ===== bench/ipv4_acl_first_match_tb.sv =====
// Self-checking testbench for the IPv4 first-match access list with a shadow rule table.
module ipv4_acl_first_match_tb;
  import acl_pkg::*;

  localparam int unsigned TABLE_DEPTH = MAX_RULES_DEF;
  localparam int unsigned RANDOM_BEATS = 360;
  localparam int unsigned FILL_DEPTH = 160;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]        func;
    logic              deny;
    logic [ADDR_W-1:0] addr;
    logic [PLEN_W-1:0] plen;
  } beat_t;

  typedef struct packed {
    logic                 verdict;
    logic                 hit;
    logic [HIT_IDX_W-1:0] hit_index;
    logic                 load_dropped;
  } acl_answer_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           func_i = FUNC_LOAD;
  logic                 rule_deny_i = 1'b0;
  logic [ADDR_W-1:0]    address_i = '0;
  logic [PLEN_W-1:0]    prefix_len_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic                 verdict_o;
  logic                 hit_o;
  logic [HIT_IDX_W-1:0] hit_index_o;
  logic                 load_dropped_o;

  beat_t       pending_beats[$];
  acl_answer_t answers_due[$];
  beat_t       cur_beat;

  logic [ADDR_W-1:0] loaded_base[$];
  logic [PLEN_W-1:0] loaded_plen[$];

  logic [ADDR_W-1:0] tbl_base[TABLE_DEPTH];
  logic [PLEN_W-1:0] tbl_plen[TABLE_DEPTH];
  logic              tbl_deny[TABLE_DEPTH];
  int unsigned       tbl_count = 0;

  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;

  ipv4_acl_first_match dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .rule_deny_i    (rule_deny_i),
    .address_i      (address_i),
    .prefix_len_i   (prefix_len_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .verdict_o      (verdict_o),
    .hit_o          (hit_o),
    .hit_index_o    (hit_index_o),
    .load_dropped_o (load_dropped_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [PLEN_W-1:0] random_plen();
    int unsigned pick;
    pick = $urandom_range(0, 31);
    if (pick == 0) begin
      return '0;
    end else if (pick < 3) begin
      return PLEN_W'($urandom_range(33, 63));
    end
    return PLEN_W'($urandom_range(1, 32));
  endfunction

  task automatic push_beat(input logic [1:0] f, input logic d, input logic [ADDR_W-1:0] a,
                           input logic [PLEN_W-1:0] p);
    beat_t b;
    b = '{func: f, deny: d, addr: a, plen: p};
    pending_beats.insert(pending_beats.size(), b);
    if (f == FUNC_LOAD && loaded_base.size() < TABLE_DEPTH) begin
      loaded_base.insert(loaded_base.size(), a);
      loaded_plen.insert(loaded_plen.size(), (p > PLEN_MAX) ? PLEN_MAX : p);
    end else if (f == FUNC_CLEAR) begin
      loaded_base.delete();
      loaded_plen.delete();
    end
  endtask

  // Query an address that lies inside the given stored rule.
  task automatic push_query_near(input int unsigned idx);
    logic [ADDR_W-1:0] mask;
    mask = ~(32'hFFFF_FFFF >> loaded_plen[idx]);
    push_beat(FUNC_QUERY, 1'($urandom_range(0, 1)),
              (loaded_base[idx] & mask) | ($urandom() & ~mask), random_plen());
  endtask

  task automatic compute_acl_answer(input beat_t b);
    acl_answer_t ans;
    logic [PLEN_W-1:0] plen;
    logic [ADDR_W-1:0] mask;
    ans = '0;
    plen = (b.plen > PLEN_MAX) ? PLEN_MAX : b.plen;
    case (b.func)
      FUNC_LOAD: begin
        if (tbl_count >= TABLE_DEPTH) begin
          ans.load_dropped = 1'b1;
        end else begin
          tbl_base[tbl_count] = b.addr;
          tbl_plen[tbl_count] = plen;
          tbl_deny[tbl_count] = b.deny;
          tbl_count++;
        end
        answers_due.insert(answers_due.size(), ans);
      end
      FUNC_QUERY: begin
        for (int unsigned k = 0; k < tbl_count; k++) begin
          mask = ~(32'hFFFF_FFFF >> tbl_plen[k]);
          if (((b.addr ^ tbl_base[k]) & mask) == '0) begin
            ans.verdict = tbl_deny[k];
            ans.hit = 1'b1;
            ans.hit_index = HIT_IDX_W'(k);
            break;
          end
        end
        answers_due.insert(answers_due.size(), ans);
      end
      FUNC_CLEAR: begin
        tbl_count = 0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_answer();
    acl_answer_t want;
    if (answers_due.size() == 0) begin
      $error("result beat with no expectation pending");
      mismatch_cnt++;
    end else begin
      want = answers_due.pop_front();
      if (verdict_o !== want.verdict) begin
        $error("verdict: expected %0d, got %0d", want.verdict, verdict_o);
        mismatch_cnt++;
      end
      if (hit_o !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, hit_o);
        mismatch_cnt++;
      end
      if (hit_index_o !== want.hit_index) begin
        $error("hit_index: expected %0d, got %0d", want.hit_index, hit_index_o);
        mismatch_cnt++;
      end
      if (load_dropped_o !== want.load_dropped) begin
        $error("load_dropped: expected %0d, got %0d", want.load_dropped, load_dropped_o);
        mismatch_cnt++;
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || in_valid_i || answers_due.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("ipv4_acl_first_match_tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        compute_acl_answer(cur_beat);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          cur_beat = pending_beats.pop_front();
          in_valid_i <= 1'b1;
          func_i <= cur_beat.func;
          rule_deny_i <= cur_beat.deny;
          address_i <= cur_beat.addr;
          prefix_len_i <= cur_beat.plen;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_answer();
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        case (cycle_cnt[10:9])
          2'd0: stall_left = 0;
          2'd1: stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
          2'd2: stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 15) : 0;
          default: stall_left = $urandom_range(0, 1);
        endcase
        out_ready_i <= (stall_left == 0);
      end
    end
  end

  initial begin
    int unsigned counted;
    int unsigned pick;
    int unsigned list_cap;
    int unsigned idx;

    push_beat(FUNC_QUERY, 1'b1, 32'h0000_0000, 6'd0);
    push_beat(FUNC_UNUSED, 1'b1, 32'hFFFF_FFFF, 6'd63);
    push_beat(FUNC_LOAD, 1'b0, 32'h0A01_0000, 6'd16);
    push_beat(FUNC_LOAD, 1'b1, 32'h0A01_0200, 6'd24);
    push_beat(FUNC_QUERY, 1'b0, 32'h0A01_0203, 6'd0);
    push_beat(FUNC_QUERY, 1'b0, 32'h0A02_0203, 6'd0);
    push_beat(FUNC_LOAD, 1'b1, 32'hC0A8_0001, 6'd32);
    push_beat(FUNC_QUERY, 1'b0, 32'hC0A8_0001, 6'd32);
    push_beat(FUNC_QUERY, 1'b0, 32'hC0A8_0002, 6'd32);
    push_beat(FUNC_LOAD, 1'b1, 32'hFFFF_FFFF, 6'd45);
    push_beat(FUNC_QUERY, 1'b1, 32'hFFFF_FFFF, 6'd63);
    push_beat(FUNC_QUERY, 1'b1, 32'hFFFF_FFFE, 6'd63);
    push_beat(FUNC_LOAD, 1'b0, 32'h0000_0000, 6'd63);
    push_beat(FUNC_QUERY, 1'b0, 32'h0000_0000, 6'd0);
    push_beat(FUNC_LOAD, 1'b0, 32'h8000_0000, 6'd1);
    push_beat(FUNC_QUERY, 1'b0, 32'hF000_0000, 6'd0);
    push_beat(FUNC_LOAD, 1'b1, 32'hDEAD_BEEF, 6'd0);
    push_beat(FUNC_QUERY, 1'b0, 32'h1234_5678, 6'd0);
    push_beat(FUNC_CLEAR, 1'b1, 32'hFFFF_FFFF, 6'd63);
    push_beat(FUNC_QUERY, 1'b0, 32'h1234_5678, 6'd0);
    push_beat(FUNC_LOAD, 1'b0, 32'h1234_5678, 6'd32);
    push_beat(FUNC_QUERY, 1'b1, 32'h1234_5678, 6'd32);
    push_beat(FUNC_CLEAR, 1'b0, 32'h0000_0000, 6'd0);
    push_beat(FUNC_CLEAR, 1'b0, 32'h0000_0000, 6'd0);
    push_beat(FUNC_QUERY, 1'b0, 32'h1234_5678, 6'd0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait_drained();

    counted = 0;
    list_cap = $urandom_range(4, 48);
    while (counted < RANDOM_BEATS) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        push_beat(FUNC_UNUSED, 1'($urandom_range(0, 1)), $urandom(), random_plen());
      end else begin
        counted++;
        if (pick < 8 || loaded_base.size() >= list_cap) begin
          push_beat(FUNC_CLEAR, 1'($urandom_range(0, 1)), $urandom(), random_plen());
          list_cap = $urandom_range(4, 48);
        end else if (pick < 45) begin
          push_beat(FUNC_LOAD, 1'($urandom_range(0, 1)), $urandom(), random_plen());
        end else if (pick < 85 && loaded_base.size() != 0) begin
          push_query_near($urandom_range(0, loaded_base.size() - 1));
        end else begin
          push_beat(FUNC_QUERY, 1'($urandom_range(0, 1)), $urandom(), random_plen());
        end
      end
    end

    wait_drained();

    push_beat(FUNC_CLEAR, 1'b0, 32'h0000_0000, 6'd0);
    for (idx = 0; idx < FILL_DEPTH; idx++) begin
      push_beat(FUNC_LOAD, 1'($urandom_range(0, 1)), $urandom(),
                ($urandom_range(0, 7) == 0) ? PLEN_W'($urandom_range(20, 31)) : PLEN_MAX);
      if (idx % 128 == 127) begin
        push_query_near(idx);
      end
    end
    push_query_near(FILL_DEPTH - 1);
    push_query_near(0);
    push_query_near(FILL_DEPTH / 2);
    push_beat(FUNC_QUERY, 1'b0, $urandom(), 6'd0);
    push_beat(FUNC_LOAD, 1'b0, $urandom(), 6'd63);
    push_beat(FUNC_LOAD, 1'b1, $urandom(), 6'd0);
    push_beat(FUNC_UNUSED, 1'b1, $urandom(), 6'd32);
    push_beat(FUNC_LOAD, 1'($urandom_range(0, 1)), $urandom(), random_plen());
    push_query_near(loaded_base.size() - 1);
    push_beat(FUNC_QUERY, 1'b1, $urandom(), 6'd63);
    push_beat(FUNC_CLEAR, 1'b0, $urandom(), 6'd0);
    push_beat(FUNC_QUERY, 1'b0, $urandom(), 6'd0);
    push_beat(FUNC_LOAD, 1'b1, $urandom(), 6'd8);
    push_query_near(0);

    wait_drained();
    repeat (TABLE_DEPTH + 16) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("ipv4_acl_first_match_tb: done, clean");
    end else begin
      $display("ipv4_acl_first_match_tb: done, errors");
    end
    $finish;
  end

endmodule
